FILE: hdl/premultiplied_alpha_rect_blit_assert.svh
// assertion macros for the premultiplied alpha blit
// used by the front, queue and back modules; no other dependencies
`ifndef PREMULTIPLIED_ALPHA_RECT_BLIT_ASSERT_SVH
`define PREMULTIPLIED_ALPHA_RECT_BLIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PAB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pab assertion failed");
`define PAB_ASSERT_NEXT(lbl, clk, rst, cond, nxt) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("pab assertion failed");
`else
`define PAB_ASSERT(lbl, clk, rst, prop)
`define PAB_ASSERT_NEXT(lbl, clk, rst, cond, nxt)
`endif
`endif

FILE: hdl/pab_pkg.sv
// shared types and constants of the premultiplied alpha blit
// no dependencies
`timescale 1ns / 1ps

package pab_pkg;

   localparam int PIX_W       = 32;
   localparam int IDX_W       = 22;
   localparam int RAW_W       = 24;
   localparam int CSR_W       = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int COORD_W     = 11;
   localparam int EXT_W       = 12;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [EXT_W-1:0] MAX_EXTENT = 12'd2048;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEST_X       = 3'd0,
      CSR_DEST_Y       = 3'd1,
      CSR_RECT_WIDTH   = 3'd2,
      CSR_RECT_HEIGHT  = 3'd3,
      CSR_SHEET_STRIDE = 3'd4
   } csr_index_type;

   // one classified item on its way from the front to the back
   typedef struct packed {
      logic [RAW_W-1:0] raw_index;
      logic [PIX_W-1:0] pixel;
      logic             opaque;
      logic             last;
   } queue_item_type;

endpackage

FILE: hdl/pab_front.sv
// front part: configuration registers, rectangle counters, raw index and classification
// depends on pab_pkg and the assertion header
`timescale 1ns / 1ps
`include "premultiplied_alpha_rect_blit_assert.svh"

module pab_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pab_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pab_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                              req_push,
   input  logic [pab_pkg::PIX_W-1:0]         req_pixel_in,
   input  logic                              q_full,
   output logic                              q_push,
   output pab_pkg::queue_item_type           q_item
);
   import pab_pkg::*;

   logic [COORD_W-1:0] dest_x_ff, dest_x_in;
   logic [COORD_W-1:0] dest_y_ff, dest_y_in;
   logic [EXT_W-1:0]   rect_width_ff, rect_width_in;
   logic [EXT_W-1:0]   rect_height_ff, rect_height_in;
   logic [EXT_W-1:0]   sheet_stride_ff, sheet_stride_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [RAW_W-1:0]   row_base_ff, row_base_in;

   logic [EXT_W-1:0]         width_eff, height_eff;
   logic [EXT_W-1:0]         col_next, row_next;
   logic [COORD_W+EXT_W-1:0] start_prod;
   logic [RAW_W-1:0]         start_base, base;
   logic                     row_end, rect_end, at_start, accept;

   function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
      if (v == '0) begin
         return EXT_W'(1);
      end else if (v > MAX_EXTENT) begin
         return MAX_EXTENT;
      end
      return v;
   endfunction

   always_comb begin
      dest_x_in       = dest_x_ff;
      dest_y_in       = dest_y_ff;
      rect_width_in   = rect_width_ff;
      rect_height_in  = rect_height_ff;
      sheet_stride_in = sheet_stride_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_X:       dest_x_in       = csr_wdata[COORD_W-1:0];
            CSR_DEST_Y:       dest_y_in       = csr_wdata[COORD_W-1:0];
            CSR_RECT_WIDTH:   rect_width_in   = csr_wdata;
            CSR_RECT_HEIGHT:  rect_height_in  = csr_wdata;
            CSR_SHEET_STRIDE: sheet_stride_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      accept     = req_push && !q_full;
      width_eff  = clamp_extent(rect_width_ff);
      height_eff = clamp_extent(rect_height_ff);
      col_next   = {1'b0, col_ff} + EXT_W'(1);
      row_next   = {1'b0, row_ff} + EXT_W'(1);
      row_end    = col_next >= width_eff;
      rect_end   = row_end && (row_next >= height_eff);
      at_start   = (col_ff == '0) && (row_ff == '0);
      start_prod = dest_y_ff * sheet_stride_ff;
      start_base = RAW_W'(start_prod) + RAW_W'(dest_x_ff);
      base       = at_start ? start_base : row_base_ff;

      col_in      = col_ff;
      row_in      = row_ff;
      row_base_in = row_base_ff;
      if (accept) begin
         row_base_in = base;
         if (rect_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in      = '0;
            row_in      = row_next[COORD_W-1:0];
            row_base_in = base + RAW_W'(sheet_stride_ff);
         end else begin
            col_in = col_next[COORD_W-1:0];
         end
      end

      q_push           = accept;
      q_item.raw_index = base + RAW_W'(col_ff);
      q_item.pixel     = req_pixel_in;
      q_item.opaque    = req_pixel_in[PIX_W-1 -: 8] == 8'hFF;
      q_item.last      = rect_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff       <= '0;
         dest_y_ff       <= '0;
         rect_width_ff   <= EXT_W'(1);
         rect_height_ff  <= EXT_W'(1);
         sheet_stride_ff <= MAX_EXTENT;
         col_ff          <= '0;
         row_ff          <= '0;
         row_base_ff     <= '0;
      end else begin
         dest_x_ff       <= dest_x_in;
         dest_y_ff       <= dest_y_in;
         rect_width_ff   <= rect_width_in;
         rect_height_ff  <= rect_height_in;
         sheet_stride_ff <= sheet_stride_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         row_base_ff     <= row_base_in;
      end
   end

   // counters restart after the final pixel of a rectangle
   `PAB_ASSERT_NEXT(a_last_restarts, clock, reset, accept && q_item.last, (col_ff == '0) && (row_ff == '0))

endmodule

FILE: hdl/pab_queue.sv
// short queue between the front and the back
// depends on pab_pkg and the assertion header
`timescale 1ns / 1ps
`include "premultiplied_alpha_rect_blit_assert.svh"

module pab_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pab_pkg::queue_item_type item_in,
   output logic                    full,
   input  logic                    pop,
   output logic                    valid,
   output pab_pkg::queue_item_type item_out
);
   import pab_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_item_type   mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   always_comb begin
      full     = count_ff == CNT_W'(QUEUE_DEPTH);
      valid    = count_ff != '0;
      item_out = mem_ff[rd_ptr_ff];
      push_ok  = push && !full;
      pop_ok   = pop && valid;

      wr_ptr_in = push_ok ? PTR_W'(wr_ptr_ff + PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? PTR_W'(rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   `PAB_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH))
   // the front never offers an item while the queue is full
   `PAB_ASSERT(a_no_push_full, clock, reset, full |-> !push)

endmodule

FILE: hdl/pab_back.sv
// back part: index reduction modulo the sheet size and alpha premultiply, three stages
// depends on pab_pkg and the assertion header
`timescale 1ns / 1ps
`include "premultiplied_alpha_rect_blit_assert.svh"

module pab_back #(
   parameter int SHEET_DIM = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  pab_pkg::queue_item_type       q_item,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [pab_pkg::IDX_W-1:0]     rsp_dest_index,
   output logic [pab_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                          rsp_last
);
   import pab_pkg::*;

   localparam longint unsigned SHEET_WORDS = longint'(SHEET_DIM) * longint'(SHEET_DIM);
   localparam int              LOG_WORDS   = $clog2(SHEET_WORDS);
   localparam int              SHIFT       = RAW_W + LOG_WORDS;
   localparam longint unsigned RECIP       = ((64'd1 << SHIFT) + SHEET_WORDS - 64'd1)
                                             / SHEET_WORDS;
   localparam int              RECIP_W     = RAW_W + 2;
   localparam int              PROD_W      = RAW_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP_K = RECIP[RECIP_W-1:0];
   localparam logic [RAW_W-1:0]   WORDS_K = RAW_W'(SHEET_WORDS);

   // stage 1
   logic                    s1_valid_ff, s1_valid_in;
   logic [RAW_W-1:0]        s1_raw_ff, s1_raw_in;
   logic [PROD_W-1:0]       s1_prod_ff, s1_prod_in;
   logic [2:0][15:0]        s1_ch_ff, s1_ch_in;
   logic [PIX_W-1:0]        s1_pixel_ff, s1_pixel_in;
   logic                    s1_opaque_ff, s1_opaque_in;
   logic                    s1_last_ff, s1_last_in;
   // stage 2
   logic                    s2_valid_ff, s2_valid_in;
   logic [RAW_W-1:0]        s2_raw_ff, s2_raw_in;
   logic [RAW_W-1:0]        s2_qc_ff, s2_qc_in;
   logic [PIX_W-1:0]        s2_pixel_ff, s2_pixel_in;
   logic                    s2_last_ff, s2_last_in;
   // stage 3, the result register
   logic                    s3_valid_ff, s3_valid_in;
   logic [RAW_W-1:0]        s3_index_ff, s3_index_in;
   logic [PIX_W-1:0]        s3_pixel_ff, s3_pixel_in;
   logic                    s3_last_ff, s3_last_in;

   logic                    adv1, adv2, adv3;
   logic [RAW_W-1:0]        quot;
   logic [7:0]              alpha;
   logic [2:0][7:0]         scaled;
   logic [2:0][16:0]        div_sum;

   always_comb begin
      adv3  = !s3_valid_ff || rsp_pop;
      adv2  = !s2_valid_ff || adv3;
      adv1  = !s1_valid_ff || adv2;
      q_pop = q_valid && adv1;

      alpha = q_item.pixel[PIX_W-1 -: 8];
      s1_valid_in  = adv1 ? q_valid : s1_valid_ff;
      s1_raw_in    = q_item.raw_index;
      s1_prod_in   = PROD_W'(q_item.raw_index) * PROD_W'(RECIP_K);
      s1_pixel_in  = q_item.pixel;
      s1_opaque_in = q_item.opaque;
      s1_last_in   = q_item.last;
      for (int i = 0; i < 3; i++) begin
         s1_ch_in[i] = 16'(q_item.pixel[8*i +: 8]) * 16'(alpha) + 16'd127;
      end

      // quotient by the sheet size, then its product for the remainder
      quot        = RAW_W'(s1_prod_ff >> SHIFT);
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s2_raw_in   = s1_raw_ff;
      s2_qc_in    = RAW_W'(quot * WORDS_K);
      s2_last_in  = s1_last_ff;
      // divide by 255 for values below 65535
      for (int i = 0; i < 3; i++) begin
         div_sum[i] = {1'b0, s1_ch_ff[i]} + 17'd1 + 17'(s1_ch_ff[i][15:8]);
         scaled[i]  = div_sum[i][15:8];
      end
      s2_pixel_in = s1_opaque_ff ? s1_pixel_ff
                  : {s1_pixel_ff[PIX_W-1 -: 8], scaled[2], scaled[1], scaled[0]};

      s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
      s3_index_in = s2_raw_ff - s2_qc_ff;
      s3_pixel_in = s2_pixel_ff;
      s3_last_in  = s2_last_ff;

      rsp_empty      = !s3_valid_ff;
      rsp_dest_index = s3_index_ff[IDX_W-1:0];
      rsp_pixel_out  = s3_pixel_ff;
      rsp_last       = s3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_raw_ff    <= s1_raw_in;
         s1_prod_ff   <= s1_prod_in;
         s1_ch_ff     <= s1_ch_in;
         s1_pixel_ff  <= s1_pixel_in;
         s1_opaque_ff <= s1_opaque_in;
         s1_last_ff   <= s1_last_in;
      end
      if (adv2) begin
         s2_raw_ff   <= s2_raw_in;
         s2_qc_ff    <= s2_qc_in;
         s2_pixel_ff <= s2_pixel_in;
         s2_last_ff  <= s2_last_in;
      end
      if (adv3) begin
         s3_index_ff <= s3_index_in;
         s3_pixel_ff <= s3_pixel_in;
         s3_last_ff  <= s3_last_in;
      end
   end

   // reduced index always lies inside the sheet
   `PAB_ASSERT(a_index_in_sheet, clock, reset, s3_valid_ff |-> longint'(s3_index_ff) < SHEET_WORDS)
   `PAB_ASSERT_NEXT(a_result_held, clock, reset, s3_valid_ff && !rsp_pop, s3_valid_ff && $stable(s3_index_ff))
   `PAB_ASSERT_NEXT(a_stage2_held, clock, reset, s2_valid_ff && !adv2, s2_valid_ff)

endmodule

FILE: hdl/premultiplied_alpha_rect_blit.sv
// top level of the premultiplied alpha rectangle blit
// depends on pab_pkg, pab_front, pab_queue and pab_back
//
//   channel   direction   handshake            payload
//   req       in          req_push / req_full  req_pixel_in
//   rsp       out         rsp_empty / rsp_pop  rsp_dest_index, rsp_pixel_out, rsp_last
//   csr       in          csr_we               csr_index, csr_wdata
//
// one pixel per clock sustained while rsp_pop drains the results; the front counters are
// registered and the raw index is combinational; a result reaches the rsp ports through
// the queue, the reciprocal multiply stage, the remainder stage and the result register
// reset clears counters, queue and stage valids and loads register defaults; no clearing pass
// rsp_pop held low fills the back stages and then the four entry queue before req_full rises
`timescale 1ns / 1ps

module premultiplied_alpha_rect_blit #(
   parameter int SHEET_DIM = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pab_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pab_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [pab_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [pab_pkg::IDX_W-1:0]        rsp_dest_index,
   output logic [pab_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic                             rsp_last
);
   import pab_pkg::*;

   logic           q_full, q_push, q_valid, q_pop;
   queue_item_type q_wr_item, q_rd_item;

   assign req_full = q_full;

   pab_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_pixel_in (req_pixel_in),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_item       (q_wr_item)
   );

   pab_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_wr_item),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .item_out (q_rd_item)
   );

   pab_back #(
      .SHEET_DIM (SHEET_DIM)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_rd_item),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_dest_index (rsp_dest_index),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: sim/blit_checker.sv
// checker for the premultiplied alpha rectangle blit: watches the csr, req and rsp ports,
// predicts each result and compares it with what the block pops
// depends on pab_pkg
`timescale 1ns / 1ps

module blit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pab_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pab_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                            req_push,
   input  logic                            req_full,
   input  logic [pab_pkg::PIX_W-1:0]       req_pixel_in,
   input  logic                            rsp_empty,
   input  logic                            rsp_pop,
   input  logic [pab_pkg::IDX_W-1:0]       rsp_dest_index,
   input  logic [pab_pkg::PIX_W-1:0]       rsp_pixel_out,
   input  logic                            rsp_last,
   output int                              failures,
   output int                              pending
);
   import pab_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] dest_index;
      logic [PIX_W-1:0] pixel;
      logic             last;
   } blit_result_type;

   blit_result_type    expected_pixels[$];

   logic [COORD_W-1:0] org_x, org_y;
   logic [EXT_W-1:0]   span_w, span_h, stride;
   logic [COORD_W-1:0] col, row;
   logic [IDX_W-1:0]   row_start;
   int                 reported = 0;

   function automatic logic [7:0] scaled(input logic [7:0] ch, input logic [7:0] a);
      logic [15:0] prod;
      prod = {8'd0, ch} * {8'd0, a} + 16'd127;
      return 8'(prod / 16'd255);
   endfunction

   function automatic int unsigned effective_extent(input logic [EXT_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_EXTENT) return MAX_EXTENT;
      return v;
   endfunction

   always @(posedge clock) begin : watch
      blit_result_type want, got;
      logic [31:0]     base_full;
      logic [7:0]      a;
      int unsigned     w, h;
      logic            row_end, rect_end;
      if (reset) begin
         org_x = '0;
         org_y = '0;
         span_w = 12'd1;
         span_h = 12'd1;
         stride = 12'd2048;
         col = '0;
         row = '0;
         row_start = '0;
         expected_pixels.delete();
         pending = 0;
         failures = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEST_X:       org_x = csr_wdata[COORD_W-1:0];
               CSR_DEST_Y:       org_y = csr_wdata[COORD_W-1:0];
               CSR_RECT_WIDTH:   span_w = csr_wdata;
               CSR_RECT_HEIGHT:  span_h = csr_wdata;
               CSR_SHEET_STRIDE: stride = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_pop && !rsp_empty) begin
            got.dest_index = rsp_dest_index;
            got.pixel = rsp_pixel_out;
            got.last = rsp_last;
            if (expected_pixels.size() == 0) begin
               failures++;
               if (reported < 10)
                  $display("unexpected item: index %0d pixel %h last %0b",
                           got.dest_index, got.pixel, got.last);
               reported++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.dest_index !== want.dest_index || got.pixel !== want.pixel ||
                   got.last !== want.last) begin
                  failures++;
                  if (reported < 10)
                     $display("mismatch: index %0d/%0d pixel %h/%h last %0b/%0b (exp/got)",
                              want.dest_index, got.dest_index, want.pixel, got.pixel,
                              want.last, got.last);
                  reported++;
               end
            end
         end

         if (req_push && !req_full) begin
            // start of rectangle reloads the row base from the current registers
            if (col == '0 && row == '0) begin
               base_full = 32'(org_y) * 32'(stride) + 32'(org_x);
               row_start = base_full[IDX_W-1:0];
            end
            w = effective_extent(span_w);
            h = effective_extent(span_h);
            row_end = (int'(col) + 1) >= w;
            rect_end = row_end && ((int'(row) + 1) >= h);

            a = req_pixel_in[31:24];
            want.dest_index = row_start + IDX_W'(col);
            if (a == 8'hFF)
               want.pixel = req_pixel_in;
            else
               want.pixel = {a, scaled(req_pixel_in[23:16], a),
                             scaled(req_pixel_in[15:8], a), scaled(req_pixel_in[7:0], a)};
            want.last = rect_end;
            expected_pixels.push_back(want);

            if (rect_end) begin
               col = '0;
               row = '0;
            end else if (row_end) begin
               col = '0;
               row = row + 1'b1;
               row_start = row_start + IDX_W'(stride);
            end else begin
               col = col + 1'b1;
            end
         end
         pending = expected_pixels.size();
      end
   end

endmodule

FILE: sim/testbench.sv
// top of the blit testbench: clock, reset, csr writes, pixel stimulus and result draining
// depends on pab_pkg, premultiplied_alpha_rect_blit and blit_checker
`timescale 1ns / 1ps

module testbench;
   import pab_pkg::*;

   localparam int TARGET_ITEMS = 1320;
   localparam int QUIET_FROM   = 1150;
   localparam int HOLD_CYCLES  = 40;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [PIX_W-1:0]       req_pixel_in = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [IDX_W-1:0]       rsp_dest_index;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic                   rsp_last;

   int                     failures;
   int                     pending;
   int                     items_sent = 0;
   int                     cycle_count = 0;
   logic                   quiet = 1'b0;
   logic                   hold_request = 1'b0;

   always #1 clock = ~clock;

   premultiplied_alpha_rect_blit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel_in   (req_pixel_in),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_dest_index (rsp_dest_index),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last       (rsp_last)
   );

   blit_checker blit_watch (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel_in   (req_pixel_in),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_dest_index (rsp_dest_index),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last       (rsp_last),
      .failures       (failures),
      .pending        (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stall bursts, plus a long hold-off on request
   initial begin : drain
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_pop <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_pixel(input logic [PIX_W-1:0] pixel);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_pixel_in <= pixel;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      @(negedge clock);
      items_sent++;
      quiet = (items_sent >= QUIET_FROM);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // stop offering items and wait until every expected item has come back
   task automatic settle();
      req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [PIX_W-1:0] p;
      p = $urandom;
      case ($urandom_range(0, 7))
         0, 1: p[31:24] = 8'hFF;
         2:    p[31:24] = 8'h00;
         default: ;
      endcase
      return p;
   endfunction

   function automatic logic [CSR_W-1:0] pick_extent();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return MAX_EXTENT;
         2:       return CSR_W'($urandom_range(2049, 4095));
         3:       return CSR_W'($urandom_range(9, 2047));
         default: return CSR_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 12'd2047;
         2:       return 12'hFFF;
         default: return CSR_W'($urandom_range(0, 4095));
      endcase
   endfunction

   initial begin : stimulus
      logic [CSR_W-1:0] w_val, h_val, s_val;
      int unsigned      eff_w, eff_h, n, phase;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: one-pixel rectangle at the origin
      send_pixel(32'hFF123456);
      send_pixel(32'h00FFFFFF);
      settle();

      // far corner with oversize stride: index wraps around the sheet
      write_reg(CSR_DEST_X, 12'hFFF);
      write_reg(CSR_DEST_Y, 12'h7FF);
      write_reg(CSR_RECT_WIDTH, 12'd2);
      write_reg(CSR_RECT_HEIGHT, 12'd2);
      write_reg(CSR_SHEET_STRIDE, 12'hFFF);
      send_pixel(32'h80FFFFFF);
      send_pixel(32'h01FF80FF);
      send_pixel(32'hFEFF0001);
      send_pixel(32'h7F808080);
      settle();

      // zero extents act as one
      write_reg(CSR_RECT_WIDTH, 12'd0);
      write_reg(CSR_RECT_HEIGHT, 12'd0);
      write_reg(CSR_SHEET_STRIDE, 12'd0);
      send_pixel(32'h00000000);
      send_pixel(32'hFFFFFFFF);
      settle();

      // oversize extents, then shrink mid-rectangle
      write_reg(CSR_DEST_X, 12'd0);
      write_reg(CSR_DEST_Y, 12'd0);
      write_reg(CSR_RECT_WIDTH, 12'hFFF);
      write_reg(CSR_RECT_HEIGHT, 12'hFFF);
      repeat (3) send_pixel(random_pixel());
      settle();
      write_reg(CSR_RECT_WIDTH, 12'd1);
      write_reg(CSR_RECT_HEIGHT, 12'd1);
      send_pixel(random_pixel());
      settle();

      // unused register indexes are ignored; zero stride repeats the same words
      for (int i = int'(CSR_SHEET_STRIDE) + 1; i < 2 ** CSR_INDEX_W; i++)
         write_reg(CSR_INDEX_W'(i), 12'hFFF);
      write_reg(CSR_DEST_X, 12'd5);
      write_reg(CSR_RECT_WIDTH, 12'd3);
      write_reg(CSR_RECT_HEIGHT, 12'd3);
      repeat (9) send_pixel(random_pixel());

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         settle();
         if ($urandom_range(0, 3) != 0) write_reg(CSR_DEST_X, pick_coord());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_DEST_Y, pick_coord());
         w_val = pick_extent();
         h_val = pick_extent();
         write_reg(CSR_RECT_WIDTH, w_val);
         write_reg(CSR_RECT_HEIGHT, h_val);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       s_val = '0;
               1:       s_val = 12'hFFF;
               2:       s_val = 12'd2048;
               3:       s_val = 12'd1;
               default: s_val = CSR_W'($urandom_range(0, 4095));
            endcase
            write_reg(CSR_SHEET_STRIDE, s_val);
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_INDEX_W'(int'(CSR_SHEET_STRIDE) + $urandom_range(1,
                      2 ** CSR_INDEX_W - 1 - int'(CSR_SHEET_STRIDE))), CSR_W'($urandom));

         eff_w = (w_val == '0) ? 1 : ((w_val > MAX_EXTENT) ? MAX_EXTENT : w_val);
         eff_h = (h_val == '0) ? 1 : ((h_val > MAX_EXTENT) ? MAX_EXTENT : h_val);
         if (eff_w * eff_h <= 48 && $urandom_range(0, 4) != 0)
            n = eff_w * eff_h * $urandom_range(1, 3);
         else
            n = $urandom_range(1, 40);
         if (phase % 8 == 3 && !quiet) begin
            hold_request = 1'b1;
            n = 30;
         end
         repeat (n) send_pixel(random_pixel());
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: premultiplied_alpha_rect_blit.f
+incdir+hdl
hdl/pab_pkg.sv
hdl/pab_front.sv
hdl/pab_queue.sv
hdl/pab_back.sv
hdl/premultiplied_alpha_rect_blit.sv
sim/blit_checker.sv
sim/testbench.sv
